FILE: hw/rtl/insertion_rank_agreement_count_assert.svh
// Assertion macros for the insertion rank agreement counter.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef INSERTION_RANK_AGREEMENT_COUNT_ASSERT_SVH
`define INSERTION_RANK_AGREEMENT_COUNT_ASSERT_SVH
`ifndef SYNTHESIS
`define IRAC_ASSERT_IMP(lbl, ant, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
        else $error("irac assertion failed");
`define IRAC_ASSERT_NXT(lbl, ant, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
        else $error("irac assertion failed");
`else
`define IRAC_ASSERT_IMP(lbl, ant, cons)
`define IRAC_ASSERT_NXT(lbl, ant, cons)
`endif
`endif

FILE: hw/rtl/irac_pkg.sv
// Package for the insertion rank agreement counter: step codes, jump
// conditions, control word type and the microcode ROM. No dependencies.
package irac_pkg;

    typedef logic [3:0] step_t;

    localparam step_t S_IDLE  = 4'd0;
    localparam step_t S_INIT  = 4'd1;
    localparam step_t S_F0    = 4'd2;
    localparam step_t S_F1    = 4'd3;
    localparam step_t S_F2    = 4'd4;
    localparam step_t S_W0    = 4'd5;
    localparam step_t S_W1    = 4'd6;
    localparam step_t S_EXIT  = 4'd7;
    localparam step_t S_LINK  = 4'd8;
    localparam step_t S_INS   = 4'd9;
    localparam step_t S_LINK2 = 4'd10;
    localparam step_t S_NEXTJ = 4'd11;
    localparam step_t S_INCJ  = 4'd12;
    localparam step_t S_DONE  = 4'd13;

    localparam logic [4:0] NPOS_RESET = 5'd16;
    localparam logic [6:0] CNT_MAX    = 7'd127;

    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_J_ZERO,
        C_CONTINUE,
        C_INSERT,
        C_AT_HEAD,
        C_J_LAST
    } cond_t;

    typedef struct packed {
        logic  clr;
        logic  ld_rank;
        logic  cmp;
        logic  wr_self;
        logic  wr_prev;
        logic  inc_j;
        logic  done;
        cond_t cond;
        step_t tgt;
    } ctrl_t;

    // jump to tgt when cond holds, else fall through to the next step
    function automatic ctrl_t ucode(input step_t pc);
        ctrl_t w;
        w = '0;
        w.cond = C_NEVER;
        w.tgt = S_IDLE;
        case (pc)
            S_INIT:
            begin
                w.clr = 1'b1;
            end
            S_F0, S_F1, S_W0:
            begin
                w.cond = C_NEVER;
            end
            S_F2:
            begin
                w.ld_rank = 1'b1;
                w.cond = C_J_ZERO;
                w.tgt = S_NEXTJ;
            end
            S_W1:
            begin
                w.cmp = 1'b1;
                w.cond = C_CONTINUE;
                w.tgt = S_W0;
            end
            S_EXIT:
            begin
                w.cond = C_INSERT;
                w.tgt = S_INS;
            end
            S_LINK:
            begin
                w.wr_prev = 1'b1;
                w.cond = C_ALWAYS;
                w.tgt = S_NEXTJ;
            end
            S_INS:
            begin
                w.wr_self = 1'b1;
                w.cond = C_AT_HEAD;
                w.tgt = S_NEXTJ;
            end
            S_LINK2:
            begin
                w.wr_prev = 1'b1;
            end
            S_NEXTJ:
            begin
                w.cond = C_J_LAST;
                w.tgt = S_DONE;
            end
            S_INCJ:
            begin
                w.inc_j = 1'b1;
                w.cond = C_ALWAYS;
                w.tgt = S_F0;
            end
            S_DONE:
            begin
                w.done = 1'b1;
                w.cond = C_ALWAYS;
                w.tgt = S_IDLE;
            end
            default:
            begin
                w.cond = C_ALWAYS;
                w.tgt = S_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

FILE: hw/rtl/insertion_rank_agreement_count.sv
// Replay: the load beat for the last slot starts a replay of the loaded records, then
// done pulses for one cycle with both counts. The sorted list is a linked list in a
// one-read-port memory: each comparison is a read step followed by a compare step.
// Throughput: load beats are taken only while idle, so no new record is accepted
// during a replay; the result cannot be stalled.
// Reset: asynchronous active low; sequencer idle, counts zero, n_positions 16.
`include "insertion_rank_agreement_count_assert.svh"

module insertion_rank_agreement_count #(
    parameter int MAX_ITEMS = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [4:0] cfg_wdata,
    input  logic       start,
    input  logic [3:0] slot,
    input  logic [3:0] presented_item,
    input  logic [3:0] completed_rank,
    input  logic [3:0] central_rank,
    output logic       busy,
    output logic       done,
    output logic [6:0] comparisons,
    output logic [6:0] agreements
);

    localparam int PW = $clog2(MAX_ITEMS);
    localparam int NW = $clog2(MAX_ITEMS + 1);
    localparam int EW = (NW > 5) ? NW : 5;
    localparam logic [EW-1:0] MaxExt = EW'(MAX_ITEMS);

    logic [4:0]          n_cfg_reg;
    irac_pkg::step_t     pc_reg, pc_next;
    logic [PW-1:0]       j_reg, j_next;
    logic [PW-1:0]       i_reg, i_next;
    logic [PW-1:0]       node_reg, node_next;
    logic [PW-1:0]       prev_reg, prev_next;
    logic [PW-1:0]       head_reg, head_next;
    logic [3:0]          cc_reg, cc_next;
    logic [3:0]          mc_reg, mc_next;
    logic [6:0]          cmp_reg, cmp_next;
    logic [6:0]          agr_reg, agr_next;

    logic [3:0]          pres_mem [MAX_ITEMS];
    logic [7:0]          rank_mem [MAX_ITEMS];
    logic [7:0]          node_mem [MAX_ITEMS];
    logic [PW-1:0]       link_mem [MAX_ITEMS];
    logic [3:0]          pres_rd_reg;
    logic [7:0]          rank_rd_reg;
    logic [7:0]          node_rd_reg;
    logic [PW-1:0]       link_rd_reg;

    irac_pkg::ctrl_t     cw;
    logic [EW-1:0]       cfg_ext, n_eff, last_ext, slot_ext, item_ext;
    logic [PW-1:0]       slot_idx, item_idx;
    logic                load, launch, item_ok;
    logic [3:0]          cc_new, mc_new;
    logic                ahead, cahead;
    logic                i_end, j_last, cond_true;
    logic                link_we;
    logic [PW-1:0]       link_wa, link_wd;

    assign cfg_ext  = EW'(n_cfg_reg);
    assign n_eff    = (cfg_ext == '0) ? EW'(1) : ((cfg_ext > MaxExt) ? MaxExt : cfg_ext);
    assign last_ext = n_eff - EW'(1);
    assign slot_ext = EW'(slot);
    assign slot_idx = slot_ext[PW-1:0];
    assign busy     = (pc_reg != irac_pkg::S_IDLE);
    assign load     = start && !busy && (slot_ext < MaxExt);
    assign launch   = load && (slot_ext == last_ext);

    assign cw = irac_pkg::ucode(pc_reg);

    // items beyond the table read as rank zero
    assign item_ext = EW'(pres_rd_reg);
    assign item_idx = item_ext[PW-1:0];
    assign item_ok  = item_ext < MaxExt;
    assign cc_new   = item_ok ? rank_rd_reg[7:4] : 4'd0;
    assign mc_new   = item_ok ? rank_rd_reg[3:0] : 4'd0;

    assign ahead   = cc_reg < node_rd_reg[7:4];
    assign cahead  = mc_reg < node_rd_reg[3:0];
    assign i_end   = ({1'b0, i_reg} + {{PW{1'b0}}, 1'b1}) == {1'b0, j_reg};
    assign j_last  = (EW'(j_reg) == last_ext);

    assign link_we = cw.wr_self || cw.wr_prev;
    assign link_wa = cw.wr_self ? j_reg : prev_reg;
    assign link_wd = cw.wr_self ? node_reg : j_reg;

    always_comb
    begin
        case (cw.cond)
            irac_pkg::C_NEVER:    cond_true = 1'b0;
            irac_pkg::C_ALWAYS:   cond_true = 1'b1;
            irac_pkg::C_J_ZERO:   cond_true = (j_reg == '0);
            irac_pkg::C_CONTINUE: cond_true = !ahead && !i_end;
            irac_pkg::C_INSERT:   cond_true = (i_reg != j_reg);
            irac_pkg::C_AT_HEAD:  cond_true = (i_reg == '0);
            irac_pkg::C_J_LAST:   cond_true = j_last;
            default:              cond_true = 1'b0;
        endcase
    end

    always_comb
    begin
        if (pc_reg == irac_pkg::S_IDLE)
            pc_next = launch ? irac_pkg::S_INIT : irac_pkg::S_IDLE;
        else if (cond_true)
            pc_next = cw.tgt;
        else
            pc_next = pc_reg + 4'd1;
    end

    always_comb
    begin
        j_next    = j_reg;
        i_next    = i_reg;
        node_next = node_reg;
        prev_next = prev_reg;
        head_next = head_reg;
        cc_next   = cc_reg;
        mc_next   = mc_reg;
        cmp_next  = cmp_reg;
        agr_next  = agr_reg;
        if (cw.clr)
        begin
            cmp_next  = '0;
            agr_next  = '0;
            j_next    = '0;
            i_next    = '0;
            head_next = '0;
        end
        if (cw.ld_rank)
        begin
            cc_next   = cc_new;
            mc_next   = mc_new;
            node_next = head_reg;
            i_next    = '0;
        end
        if (cw.cmp)
        begin
            cmp_next = (cmp_reg < irac_pkg::CNT_MAX) ? cmp_reg + 7'd1 : irac_pkg::CNT_MAX;
            if (ahead == cahead)
                agr_next = (agr_reg < irac_pkg::CNT_MAX) ? agr_reg + 7'd1 : irac_pkg::CNT_MAX;
            if (!ahead)
            begin
                prev_next = node_reg;
                node_next = link_rd_reg;
                i_next    = i_reg + PW'(1);
            end
        end
        if (cw.wr_self && (i_reg == '0))
            head_next = j_reg;
        if (cw.inc_j)
            j_next = j_reg + PW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_cfg_reg <= irac_pkg::NPOS_RESET;
            pc_reg    <= irac_pkg::S_IDLE;
            cmp_reg   <= '0;
            agr_reg   <= '0;
            j_reg     <= '0;
            i_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
                n_cfg_reg <= cfg_wdata;
            pc_reg  <= pc_next;
            cmp_reg <= cmp_next;
            agr_reg <= agr_next;
            j_reg   <= j_next;
            i_reg   <= i_next;
        end
    end

    always_ff @(posedge clk)
    begin
        node_reg <= node_next;
        prev_reg <= prev_next;
        head_reg <= head_next;
        cc_reg   <= cc_next;
        mc_reg   <= mc_next;
    end

    // record stores, written by load beats
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pres_mem[slot_idx] <= presented_item;
            rank_mem[slot_idx] <= {completed_rank, central_rank};
        end
        pres_rd_reg <= pres_mem[j_reg];
        rank_rd_reg <= rank_mem[item_idx];
    end

    // sorted list nodes: ranks and next link, indexed by presentation position
    always_ff @(posedge clk)
    begin
        if (cw.ld_rank)
            node_mem[j_reg] <= {cc_new, mc_new};
        if (link_we)
            link_mem[link_wa] <= link_wd;
        node_rd_reg <= node_mem[node_reg];
        link_rd_reg <= link_mem[node_reg];
    end

    assign done        = cw.done;
    assign comparisons = cmp_reg;
    assign agreements  = agr_reg;

    `IRAC_ASSERT_IMP(a_agr_le_cmp, 1'b1, agr_reg <= cmp_reg)
    `IRAC_ASSERT_IMP(a_walk_bound, busy, i_reg <= j_reg)
    `IRAC_ASSERT_NXT(a_launch_busy, launch, busy)
    `IRAC_ASSERT_NXT(a_done_pulse, done, !done)

endmodule
